>>> rtl/nwt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nwt_pkg
// Shared widths, word codes and state types for the number-to-words block.
// ----------------------------------------------------------------------------
package nwt_pkg;

    localparam int VALUE_W    = 31;   // input integer width
    localparam int NUM_DIGITS = 10;   // decimal digits of a 31-bit value
    localparam int CODE_W     = 5;    // word code width
    localparam int IN_TDATA_W = 32;   // value padded to whole bytes
    localparam int OUT_TDATA_W = 8;   // word code padded to whole bytes

    localparam logic [CODE_W-1:0] CODE_ZERO    = 5'd0;
    localparam logic [CODE_W-1:0] CODE_TEN     = 5'd10;
    localparam logic [CODE_W-1:0] CODE_TENS0   = 5'd18;
    localparam logic [CODE_W-1:0] CODE_HUNDRED = 5'd28;

    typedef logic [NUM_DIGITS-1:0][3:0] t_digits;

    typedef enum logic [1:0] {
        CTL_IDLE,
        CTL_CONV,
        CTL_SPELL
    } t_ctl_state;

    typedef enum logic [2:0] {
        STEP_IDLE,
        STEP_ZERO,
        STEP_HUND,
        STEP_HWORD,
        STEP_TENS,
        STEP_ONES,
        STEP_SCALE
    } t_step;

    // handshake between the control FSM and the two engines
    typedef struct packed {
        logic start;
    } t_eng_cmd;

    typedef struct packed {
        logic done;
    } t_eng_sts;

endpackage
`default_nettype wire

>>> rtl/nwt_bcd.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nwt_bcd
// Bit-serial binary to BCD converter (shift and add-3), one bit per cycle.
// ----------------------------------------------------------------------------
module nwt_bcd (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  nwt_pkg::t_eng_cmd                i_cmd,
    input  wire  [nwt_pkg::VALUE_W-1:0]      i_value,
    output nwt_pkg::t_eng_sts                o_sts,
    output nwt_pkg::t_digits                 o_digits
);

    localparam int CNT_W = $clog2(nwt_pkg::VALUE_W + 1);
    localparam int FLAT_W = 4 * nwt_pkg::NUM_DIGITS;

    logic [nwt_pkg::VALUE_W-1:0] r_bin, n_bin;
    nwt_pkg::t_digits            r_bcd, n_bcd;
    nwt_pkg::t_digits            adj;
    logic [FLAT_W-1:0]           adj_flat;
    logic [CNT_W-1:0]            r_cnt, n_cnt;
    logic                        r_busy, n_busy;
    logic                        r_done, n_done;

    always_comb begin
        for (int k = 0; k < nwt_pkg::NUM_DIGITS; k++) begin
            adj[k] = (r_bcd[k] >= 4'd5) ? (r_bcd[k] + 4'd3) : r_bcd[k];
        end
        adj_flat = adj;
    end

    always_comb begin
        n_bin  = r_bin;
        n_bcd  = r_bcd;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_cmd.start) begin
            n_bin  = i_value;
            n_bcd  = '0;
            n_cnt  = CNT_W'(nwt_pkg::VALUE_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_bcd = {adj_flat[FLAT_W-2:0], r_bin[nwt_pkg::VALUE_W-1]};
            n_bin = {r_bin[nwt_pkg::VALUE_W-2:0], 1'b0};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin <= n_bin;
        r_bcd <= n_bcd;
    end

    assign o_sts.done = r_done;
    assign o_digits   = r_bcd;

endmodule
`default_nettype wire

>>> rtl/nwt_speller.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nwt_speller
// Walks the digit groups from billion down to units and emits one word
// code per beat through an output register.
// ----------------------------------------------------------------------------
module nwt_speller (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  nwt_pkg::t_eng_cmd                 i_cmd,
    input  nwt_pkg::t_digits                  i_digits,
    output nwt_pkg::t_eng_sts                 o_sts,
    output logic                              o_m_tvalid,
    input  wire                               i_m_tready,
    output logic [nwt_pkg::CODE_W-1:0]        o_code,
    output logic                              o_m_tlast
);

    nwt_pkg::t_step              r_step, n_step;
    logic [1:0]                  r_grp, n_grp;
    logic                        r_done, n_done;
    logic                        r_valid;
    logic [nwt_pkg::CODE_W-1:0]  r_code;
    logic                        r_last;

    logic [3:0]                  d_h, d_t, d_o;
    logic                        lower_zero;
    logic                        grp_nz;
    logic                        emit;
    logic [nwt_pkg::CODE_W-1:0]  emit_code;
    logic                        emit_last;
    logic                        slot_free;
    logic                        stall;
    logic                        units_grp;

    // digits of the current group; billion group has only one digit
    always_comb begin
        case (r_grp)
            2'd3: begin
                d_h = 4'd0; d_t = 4'd0; d_o = i_digits[9];
                lower_zero = (i_digits[8:0] == '0);
            end
            2'd2: begin
                d_h = i_digits[8]; d_t = i_digits[7]; d_o = i_digits[6];
                lower_zero = (i_digits[5:0] == '0);
            end
            2'd1: begin
                d_h = i_digits[5]; d_t = i_digits[4]; d_o = i_digits[3];
                lower_zero = (i_digits[2:0] == '0);
            end
            default: begin
                d_h = i_digits[2]; d_t = i_digits[1]; d_o = i_digits[0];
                lower_zero = 1'b1;
            end
        endcase
    end

    assign grp_nz    = (d_h != 4'd0) || (d_t != 4'd0) || (d_o != 4'd0);
    assign units_grp = (r_grp == 2'd0);
    assign slot_free = !r_valid || i_m_tready;
    assign stall     = emit && !slot_free;

    // token outputs of the current step
    always_comb begin
        emit      = 1'b0;
        emit_code = nwt_pkg::CODE_ZERO;
        emit_last = 1'b0;
        case (r_step)
            nwt_pkg::STEP_ZERO: begin
                emit      = 1'b1;
                emit_code = nwt_pkg::CODE_ZERO;
                emit_last = 1'b1;
            end
            nwt_pkg::STEP_HUND: begin
                emit      = (d_h != 4'd0);
                emit_code = {1'b0, d_h};
            end
            nwt_pkg::STEP_HWORD: begin
                emit      = (d_h != 4'd0);
                emit_code = nwt_pkg::CODE_HUNDRED;
                emit_last = units_grp && (d_t == 4'd0) && (d_o == 4'd0);
            end
            nwt_pkg::STEP_TENS: begin
                if (d_t >= 4'd2) begin
                    emit      = 1'b1;
                    emit_code = nwt_pkg::CODE_TENS0 + {1'b0, d_t};
                    emit_last = units_grp && (d_o == 4'd0);
                end else if (d_t == 4'd1) begin
                    emit      = 1'b1;
                    emit_code = nwt_pkg::CODE_TEN + {1'b0, d_o};
                    emit_last = units_grp;
                end else begin
                    emit      = (d_o != 4'd0);
                    emit_code = {1'b0, d_o};
                    emit_last = units_grp;
                end
            end
            nwt_pkg::STEP_ONES: begin
                emit      = (d_t >= 4'd2) && (d_o != 4'd0);
                emit_code = {1'b0, d_o};
                emit_last = units_grp;
            end
            nwt_pkg::STEP_SCALE: begin
                emit      = !units_grp && grp_nz;
                emit_code = nwt_pkg::CODE_HUNDRED + {3'b000, r_grp};
                emit_last = lower_zero;
            end
            default: begin
                emit      = 1'b0;
                emit_code = nwt_pkg::CODE_ZERO;
                emit_last = 1'b0;
            end
        endcase
    end

    // next step
    always_comb begin
        n_step = r_step;
        n_grp  = r_grp;
        n_done = 1'b0;
        case (r_step)
            nwt_pkg::STEP_IDLE: begin
                if (i_cmd.start) begin
                    n_grp  = 2'd3;
                    n_step = (i_digits == '0) ? nwt_pkg::STEP_ZERO : nwt_pkg::STEP_HUND;
                end
            end
            nwt_pkg::STEP_ZERO: begin
                if (!stall) begin
                    n_step = nwt_pkg::STEP_IDLE;
                    n_done = 1'b1;
                end
            end
            nwt_pkg::STEP_HUND: begin
                if (!grp_nz) begin
                    // empty group: skip straight to the next one
                    if (units_grp) begin
                        n_step = nwt_pkg::STEP_IDLE;
                        n_done = 1'b1;
                    end else begin
                        n_grp = r_grp - 2'd1;
                    end
                end else if (!stall) begin
                    n_step = nwt_pkg::STEP_HWORD;
                end
            end
            nwt_pkg::STEP_HWORD: if (!stall) n_step = nwt_pkg::STEP_TENS;
            nwt_pkg::STEP_TENS:  if (!stall) n_step = nwt_pkg::STEP_ONES;
            nwt_pkg::STEP_ONES:  if (!stall) n_step = nwt_pkg::STEP_SCALE;
            nwt_pkg::STEP_SCALE: begin
                if (!stall) begin
                    if (units_grp) begin
                        n_step = nwt_pkg::STEP_IDLE;
                        n_done = 1'b1;
                    end else begin
                        n_step = nwt_pkg::STEP_HUND;
                        n_grp  = r_grp - 2'd1;
                    end
                end
            end
            default: n_step = nwt_pkg::STEP_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= nwt_pkg::STEP_IDLE;
            r_grp   <= '0;
            r_done  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_step <= n_step;
            r_grp  <= n_grp;
            r_done <= n_done;
            if (emit && slot_free) begin
                r_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit && slot_free) begin
            r_code <= emit_code;
            r_last <= emit_last;
        end
    end

    assign o_sts.done = r_done;
    assign o_m_tvalid = r_valid;
    assign o_code     = r_code;
    assign o_m_tlast  = r_last;

endmodule
`default_nettype wire

>>> rtl/number_to_word_tokens_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// number_to_word_tokens_top
// Spells a 31-bit unsigned integer as a stream of English word codes.
// ----------------------------------------------------------------------------
// One value is taken per run. After the input beat the value is converted to
// ten BCD digits by a shift-and-add-3 register, one bit per cycle. The speller
// then walks the billion, million, thousand and unit groups: an all-zero group
// is skipped, a nonzero group steps through hundreds digit, hundred word, tens,
// ones and scale word, and each word leaves as one output beat with tlast on
// the final word. tdata bit 31 on the input is ignored. Zero spells as the
// single word code 0.
// ----------------------------------------------------------------------------
module number_to_word_tokens_top (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire  [nwt_pkg::IN_TDATA_W-1:0]      s_axis_tdata,   // [30:0] value, [31] pad, ignored
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    output logic [nwt_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,   // [4:0] word_code, [7:5] zero
    output logic                                m_axis_tlast    // last_word
);

    nwt_pkg::t_ctl_state          r_state, n_state;
    nwt_pkg::t_eng_cmd            bcd_cmd, spl_cmd;
    nwt_pkg::t_eng_sts            bcd_sts, spl_sts;
    nwt_pkg::t_digits             digits;
    logic [nwt_pkg::CODE_W-1:0]   code;
    logic                         in_beat;

    assign in_beat = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            nwt_pkg::CTL_IDLE:  if (in_beat)      n_state = nwt_pkg::CTL_CONV;
            nwt_pkg::CTL_CONV:  if (bcd_sts.done) n_state = nwt_pkg::CTL_SPELL;
            nwt_pkg::CTL_SPELL: if (spl_sts.done) n_state = nwt_pkg::CTL_IDLE;
            default:                              n_state = nwt_pkg::CTL_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = (r_state == nwt_pkg::CTL_IDLE);
        bcd_cmd.start = in_beat;
        spl_cmd.start = (r_state == nwt_pkg::CTL_CONV) && bcd_sts.done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nwt_pkg::CTL_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    nwt_bcd u_bcd (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (bcd_cmd),
        .i_value  (s_axis_tdata[nwt_pkg::VALUE_W-1:0]),
        .o_sts    (bcd_sts),
        .o_digits (digits)
    );

    nwt_speller u_speller (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (spl_cmd),
        .i_digits   (digits),
        .o_sts      (spl_sts),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_code     (code),
        .o_m_tlast  (m_axis_tlast)
    );

    assign m_axis_tdata = {{(nwt_pkg::OUT_TDATA_W - nwt_pkg::CODE_W){1'b0}}, code};

endmodule
`default_nettype wire

>>> bench/number_to_word_tokens_checker.sv
// ----------------------------------------------------------------------------
// number_to_word_tokens_checker
// Watches both stream ports of the number-to-words block. Each accepted value
// is spelled into its expected word codes, and each word beat on the output is
// compared in order against them. Errors and open words go back to the bench.
// ----------------------------------------------------------------------------
module number_to_word_tokens_checker
    import nwt_pkg::*;
(
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_in_tvalid,
    input  wire                     i_in_tready,
    input  wire  [IN_TDATA_W-1:0]   i_in_tdata,    // [30:0] value, [31] ignored
    input  wire                     i_out_tvalid,
    input  wire                     i_out_tready,
    input  wire  [OUT_TDATA_W-1:0]  i_out_tdata,   // [4:0] word_code, [7:5] zero
    input  wire                     i_out_tlast,   // last_word
    output int                      o_err_count,
    output int                      o_pending
);

    localparam logic [CODE_W-1:0] WORD_THOUSAND = 5'd29;
    localparam logic [CODE_W-1:0] WORD_MILLION  = 5'd30;
    localparam logic [CODE_W-1:0] WORD_BILLION  = 5'd31;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              last;
    } t_word;

    t_word             word_q[$];   // words still owed by the block
    logic [CODE_W-1:0] spell_buf[$];
    t_word             want;
    int                err_count = 0;
    int                n_open    = 0;

    assign o_err_count = err_count;
    assign o_pending   = n_open;

    // append one word code to the spelling of the current value
    task automatic add_code(input logic [CODE_W-1:0] c);
        spell_buf = {spell_buf, c};
    endtask

    // words for one three-digit group, scale word not included
    task automatic spell_group(input int unsigned grp);
        int unsigned hund;
        int unsigned rest;
        hund = grp / 100;
        rest = grp % 100;
        if (hund != 0) begin
            add_code(CODE_W'(hund));
            add_code(CODE_HUNDRED);
        end
        if (rest >= 20) begin
            add_code(CODE_TENS0 + CODE_W'(rest / 10));
            if (rest % 10 != 0)
                add_code(CODE_W'(rest % 10));
        end else if (rest != 0) begin
            add_code(CODE_W'(rest));
        end
    endtask

    task automatic spell_value(input logic [VALUE_W-1:0] value);
        int unsigned v;
        int unsigned grp [4];
        t_word       w;
        spell_buf.delete();
        v = value;
        if (v == 0) begin
            add_code(CODE_ZERO);
        end else begin
            for (int g = 0; g < 4; g++) begin
                grp[g] = v % 1000;
                v      = v / 1000;
            end
            // billion group first, units last
            for (int g = 3; g >= 0; g--) begin
                if (grp[g] != 0) begin
                    spell_group(grp[g]);
                    case (g)
                        3: add_code(WORD_BILLION);
                        2: add_code(WORD_MILLION);
                        1: add_code(WORD_THOUSAND);
                        default: ;
                    endcase
                end
            end
        end
        foreach (spell_buf[k]) begin
            w.code = spell_buf[k];
            w.last = (k == spell_buf.size() - 1);
            word_q = {word_q, w};
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_out_tvalid && i_out_tready) begin
                if (word_q.size() == 0) begin
                    $display("%0t: word beat with nothing expected: tdata %0d last %0b",
                             $time, i_out_tdata, i_out_tlast);
                    err_count++;
                end else begin
                    want = word_q.pop_front();
                    if (i_out_tdata !== {{(OUT_TDATA_W-CODE_W){1'b0}}, want.code}) begin
                        $display("%0t: word_code mismatch: expected %0d, got tdata %0d",
                                 $time, want.code, i_out_tdata);
                        err_count++;
                    end
                    if (i_out_tlast !== want.last) begin
                        $display("%0t: last_word mismatch: expected %0b, got %0b",
                                 $time, want.last, i_out_tlast);
                        err_count++;
                    end
                end
            end
            // bit 31 of the input beat is padding
            if (i_in_tvalid && i_in_tready)
                spell_value(i_in_tdata[VALUE_W-1:0]);
            n_open = word_q.size();
        end
    end

endmodule

>>> bench/tb_number_to_word_tokens_top.sv
// ----------------------------------------------------------------------------
// tb_number_to_word_tokens_top
// Drives values into the number-to-words block through directed corner cases
// and random values built from mixed digit groups, under four idle/stall
// phases; the checker predicts and compares every word beat.
// ----------------------------------------------------------------------------
module tb_number_to_word_tokens_top;
    import nwt_pkg::*;

    localparam int PHASE_ITEMS = 65;
    localparam int LIMIT       = 400000;
    localparam int DRAIN       = 80;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // [30:0] value, [31] pad
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;        // [4:0] word_code, [7:5] zero
    logic                   m_axis_tlast;        // last_word

    int err_count;
    int words_open;
    int cycle_cnt      = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    number_to_word_tokens_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    number_to_word_tokens_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_tvalid  (s_axis_tvalid),
        .i_in_tready  (s_axis_tready),
        .i_in_tdata   (s_axis_tdata),
        .i_out_tvalid (m_axis_tvalid),
        .i_out_tready (m_axis_tready),
        .i_out_tdata  (m_axis_tdata),
        .i_out_tlast  (m_axis_tlast),
        .o_err_count  (err_count),
        .o_pending    (words_open)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        m_axis_tready = ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin
        while (cycle_cnt < LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // called at a falling edge; returns at the falling edge after the beat
    task automatic send_value(input logic [IN_TDATA_W-1:0] data);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = data;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    // random value from digit groups of mixed shape, some groups empty
    function automatic logic [IN_TDATA_W-1:0] grouped_value();
        longint unsigned v;
        int unsigned     grp;
        v = $urandom_range(0, 2);
        for (int g = 0; g < 3; g++) begin
            case ($urandom_range(0, 3))
                0: grp = 0;
                1: grp = $urandom_range(1, 19);
                2: grp = $urandom_range(20, 99);
                default: grp = $urandom_range(100, 999);
            endcase
            v = v * 1000 + grp;
        end
        if (v > 64'd2147483647)
            v = v - 64'd1000000000;
        return {1'($urandom_range(0, 1)), v[VALUE_W-1:0]};
    endfunction

    function automatic logic [IN_TDATA_W-1:0] random_value();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 60)
            return grouped_value();
        else if (pick < 85)
            return $urandom;
        else
            return IN_TDATA_W'($urandom_range(0, 1000));
    endfunction

    initial begin
        logic [IN_TDATA_W-1:0] corner [$];
        corner = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd11, 32'd19, 32'd20, 32'd21,
                   32'd99, 32'd100, 32'd101, 32'd115, 32'd999, 32'd1000, 32'd1001,
                   32'd1000000, 32'd20020020, 32'd1000000000, 32'd2000000000,
                   32'd1111111111, 32'd1777777777, 32'd2147483647,
                   32'h8000_0000, 32'hFFFF_FFFF, 32'd1234567891};

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // no idling: corners, then random
        foreach (corner[k])
            send_value(corner[k]);
        repeat (PHASE_ITEMS - corner.size()) send_value(random_value());

        // sender sparse
        send_idle_pct = 73;
        repeat (PHASE_ITEMS) send_value(random_value());

        // hold the sender off until every word is out
        s_axis_tvalid = 1'b0;
        while (words_open != 0) @(negedge i_clk);

        // receiver stalling
        send_idle_pct  = 0;
        recv_stall_pct = 73;
        repeat (PHASE_ITEMS) send_value(random_value());

        // light idling on both sides
        send_idle_pct  = 19;
        recv_stall_pct = 19;
        repeat (PHASE_ITEMS) send_value(random_value());
        s_axis_tvalid = 1'b0;

        recv_stall_pct = 0;
        while (words_open != 0) @(negedge i_clk);
        repeat (DRAIN) @(negedge i_clk);

        if (err_count == 0 && words_open == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
